// File: src/sfr_pkg.sv
// Types and constants shared by the serial frame receiver.
package sfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'hAA;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'h55;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_FIRST  = 1'b0,
    CFG_HEADER_SECOND = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    PH_HEAD1 = 6'b000001,
    PH_HEAD2 = 6'b000010,
    PH_CMD   = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_SUM   = 6'b100000
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] length;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] byte_index;
  } res_t;

endpackage

// File: src/sfr_chan_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
interface sfr_in_if;
  import sfr_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface sfr_out_if;
  import sfr_pkg::*;
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/sfr_core.sv
// Frame parser: header hunt, command/length capture, payload and checksum.
module sfr_core #(
  parameter int unsigned MaxPayload = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sfr_pkg::ByteW-1:0]         cfg_data_i,
  input  logic                              fire_i,
  input  logic [sfr_pkg::ByteW-1:0]         byte_i,
  output logic                              res_valid_o,
  output sfr_pkg::res_t                     res_o
);
  import sfr_pkg::*;

  localparam logic [ByteW-1:0] MaxLen = ByteW'(MaxPayload);

  logic [ByteW-1:0] hdr_first_q, hdr_second_q;
  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] cmd_q, cmd_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0] sum_q, sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HeaderFirstRst;
      hdr_second_q <= HeaderSecondRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER_FIRST:  hdr_first_q  <= cfg_data_i;
        CFG_HEADER_SECOND: hdr_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_PAYLOAD, command: cmd_q, length: len_q,
                    payload_byte: '0, byte_index: '0};
    unique case (phase_q)
      PH_HEAD2: begin
        // second header wins when both header values are equal
        if (byte_i == hdr_second_q) phase_d = PH_CMD;
        else if (byte_i == hdr_first_q) phase_d = PH_HEAD2;
        else phase_d = PH_HEAD1;
      end
      PH_CMD: begin
        cmd_d   = byte_i;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d = byte_i;
        cnt_d = '0;
        sum_d = cmd_q + byte_i;
        if (byte_i > MaxLen) phase_d = PH_HEAD1;
        else if (byte_i != '0) phase_d = PH_DATA;
        else phase_d = PH_SUM;
      end
      PH_DATA: begin
        res_valid_o        = 1'b1;
        res_o.payload_byte = byte_i;
        res_o.byte_index   = cnt_q;
        sum_d              = sum_q + byte_i;
        cnt_d              = cnt_q + ByteW'(1);
        if (cnt_d == len_q) phase_d = PH_SUM;
      end
      PH_SUM: begin
        res_valid_o = 1'b1;
        res_o.kind  = (byte_i == sum_q) ? KIND_GOOD : KIND_BAD;
        phase_d     = PH_HEAD1;
      end
      default: begin
        phase_d = (byte_i == hdr_first_q) ? PH_HEAD2 : PH_HEAD1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD1;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

endmodule

// File: src/sfr_out_reg.sv
// Result register: holds one result item until the downstream side takes it.
module sfr_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic          res_valid_i,
  input  sfr_pkg::res_t res_i,
  output logic          in_ready_o,
  sfr_out_if.source     out_ch
);
  import sfr_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  // a new byte may enter when the slot is empty or being drained this cycle
  assign in_ready_o = !valid_q || out_ch.ready;

  always_comb begin
    valid_d = valid_q;
    if (out_ch.ready) valid_d = 1'b0;
    if (fire_i) valid_d = res_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_ch.valid = valid_q;
  assign out_ch.data  = data_q;

endmodule

// File: src/serial_frame_receiver_unit.sv
// Serial frame receiver top level.
// Accepts one received byte per cycle while the result register can take it, and
// deframes header_first, header_second, command, length, payload and an 8-bit
// additive checksum over command, length and payload. Each payload byte leaves as a
// result item with its index; the checksum byte leaves a good or bad status with
// command and length. Oversize lengths (above MaxPayload) drop the frame without a
// result. The parser updates its state in the cycle it takes the byte and writes the
// result register, so a new byte is taken whenever that register is empty or is
// being read out in the same cycle. Results appear in the cycle after their byte.
module serial_frame_receiver_unit #(
  parameter int unsigned MaxPayload = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfr_pkg::ByteW-1:0]   cfg_data_i,
  sfr_in_if.sink                      in_ch,
  sfr_out_if.source                   out_ch
);
  import sfr_pkg::*;

  logic fire;
  logic res_valid;
  res_t res;
  logic in_ready;

  assign in_ch.ready = in_ready;
  assign fire        = in_ch.valid && in_ready;

  sfr_core #(
    .MaxPayload(MaxPayload)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .byte_i     (in_ch.byte_in),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  sfr_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .res_valid_i(res_valid),
    .res_i      (res),
    .in_ready_o (in_ready),
    .out_ch     (out_ch)
  );

endmodule
